>>> hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off during reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/wrc_pkg.sv
// ---------------------------------------------------------------------------
// wrc_pkg
// Shared constants, types and helpers of the word repeat counter.
// ---------------------------------------------------------------------------
package wrc_pkg;

   localparam int MAX_WORDS = 32;
   localparam int MAX_LEN   = 16;
   localparam int IDX_W     = $clog2(MAX_WORDS);
   localparam int POS_W     = $clog2(MAX_LEN);
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int USED_W    = $clog2(MAX_WORDS + 1);
   localparam int CNT_W     = 10;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // controller to datapath commands
   typedef struct packed {
      logic take_byte;  // latch the input beat and append to word
      logic clr_scan;   // start a table scan at entry 0
      logic cmp_load;   // load entry / byte compare registers
      logic next_byte;  // advance byte pointer
      logic next_entry; // advance to next entry
      logic write_hit;  // bump count of matched entry
      logic write_new;  // append word as a new entry
      logic copy_byte;  // copy one word byte into the table
      logic load_rsp;   // build the result beat
      logic word_clr;   // clear the pending word
      logic tab_clr;    // clear entries used
   } wrc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_delim;
      logic eot;
      logic word_empty;
      logic scan_end;   // no more used entries
      logic len_eq;     // stored length matches
      logic byte_eq;    // current stored byte matches
      logic bytes_end;  // byte pointer reached last byte
      logic tab_full;
   } wrc_sts_type;

   function automatic logic is_delimiter(input logic [7:0] c);
      return c == 8'h20 || c == 8'h2E || c == 8'h21 || c == 8'h2F || c == 8'h3F ||
             c == 8'h00 || c == 8'h2C || c == 8'h3B || c == 8'h28 || c == 8'h29;
   endfunction

endpackage

>>> hdl/wrc_datapath.sv
// ---------------------------------------------------------------------------
// wrc_datapath
// Word buffer, table memories, compare and count logic, result register.
// ---------------------------------------------------------------------------
module wrc_datapath import wrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_byte,
   input  logic              req_eot,
   input  wrc_cmd_type       cmd,
   output wrc_sts_type       sts,
   output logic [23:0]       rsp_data
);

   logic [7:0]        word_ff [MAX_LEN];
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              trunc_ff, trunc_in;
   logic [7:0]        byte_ff;
   logic              eot_ff;
   logic [USED_W-1:0] used_ff, used_in;
   logic [USED_W-1:0] ent_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              found_ff;

   // table memories
   logic [7:0]        mem_bytes [MAX_WORDS*MAX_LEN];
   logic [LEN_W-1:0]  mem_len   [MAX_WORDS];
   logic [CNT_W-1:0]  mem_cnt   [MAX_WORDS];
   logic [7:0]        rd_byte_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic [CNT_W-1:0]  rd_cnt_ff;

   logic [IDX_W-1:0]  ent_idx;
   logic [IDX_W+POS_W-1:0] baddr;
   logic [CNT_W-1:0]  cnt_next;

   assign ent_idx = ent_ff[IDX_W-1:0];
   assign baddr   = {ent_idx, pos_ff};

   // pending word
   always_comb begin
      len_in   = len_ff;
      trunc_in = trunc_ff;
      if (cmd.word_clr) begin
         len_in   = '0;
         trunc_in = 1'b0;
      end else if (cmd.take_byte && !is_delimiter(req_byte)) begin
         if (len_ff < LEN_W'(MAX_LEN)) len_in = len_ff + 1'b1;
         else trunc_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         trunc_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         trunc_ff <= trunc_in;
      end
      if (cmd.take_byte) begin
         byte_ff <= req_byte;
         eot_ff  <= req_eot;
         if (!is_delimiter(req_byte) && len_ff < LEN_W'(MAX_LEN))
            word_ff[len_ff[POS_W-1:0]] <= req_byte;
      end
   end

   // entries used
   always_comb begin
      used_in = used_ff;
      if (cmd.tab_clr) used_in = '0;
      else if (cmd.write_new) used_in = used_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else used_ff <= used_in;
   end

   // scan pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff   <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.clr_scan) begin
            ent_ff   <= '0;
            pos_ff   <= '0;
            found_ff <= 1'b0;
         end else if (cmd.next_entry) begin
            ent_ff <= ent_ff + 1'b1;
            pos_ff <= '0;
         end else if (cmd.next_byte || cmd.copy_byte) begin
            pos_ff <= pos_ff + 1'b1;
         end
         if (cmd.write_hit) found_ff <= 1'b1;
         if (cmd.write_new) ent_ff <= used_ff;
      end
   end

   // memory reads, registered
   always_ff @(posedge clock) begin
      if (cmd.cmp_load) begin
         rd_byte_ff <= mem_bytes[baddr];
         rd_len_ff  <= mem_len[ent_idx];
         rd_cnt_ff  <= mem_cnt[ent_idx];
      end
   end

   assign cnt_next = (rd_cnt_ff == COUNT_MAX) ? rd_cnt_ff : rd_cnt_ff + 1'b1;

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.write_hit) mem_cnt[ent_idx] <= cnt_next;
      if (cmd.write_new) begin
         mem_len[used_ff[IDX_W-1:0]] <= len_ff;
         mem_cnt[used_ff[IDX_W-1:0]] <= CNT_W'(1);
      end
      if (cmd.copy_byte) mem_bytes[baddr] <= word_ff[pos_ff];
   end

   // status
   always_comb begin
      sts.is_delim   = is_delimiter(byte_ff);
      sts.eot        = eot_ff;
      sts.word_empty = (len_ff == '0);
      sts.scan_end   = (ent_ff >= used_ff);
      sts.len_eq     = (rd_len_ff == len_ff);
      sts.byte_eq    = (rd_byte_ff == word_ff[pos_ff]);
      sts.bytes_end  = ({1'b0, pos_ff} + 1'b1 >= len_ff);
      sts.tab_full   = (used_ff == USED_W'(MAX_WORDS));
   end

   // result beat: index, count, new, repeat, trunc, full, done
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (sts.word_empty) begin
            rsp_data <= 24'(1) << 19;
         end else if (found_ff) begin
            rsp_data <= {4'd0, eot_ff, 1'b0, trunc_ff, (rd_cnt_ff > 1), 1'b0,
                         rd_cnt_ff, ent_idx};
         end else if (ent_ff < used_ff) begin
            rsp_data <= {4'd0, eot_ff, 1'b0, trunc_ff, 1'b0, 1'b1,
                         CNT_W'(1), ent_idx};
         end else begin
            rsp_data <= {4'd0, eot_ff, 1'b1, trunc_ff, 17'd0};
         end
      end
   end

endmodule

>>> hdl/wrc_ctrl.sv
// ---------------------------------------------------------------------------
// wrc_ctrl
// Sequencer: takes a beat, scans the table, updates it, hands out a result.
// ---------------------------------------------------------------------------
module wrc_ctrl import wrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output wrc_cmd_type cmd,
   input  wrc_sts_type sts
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DEC   = 9'b000000010,
      S_LOAD  = 9'b000000100,
      S_CMP   = 9'b000001000,
      S_HIT   = 9'b000010000,
      S_COPY  = 9'b000100000,
      S_RSP   = 9'b001000000,
      S_WAIT  = 9'b010000000,
      S_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.take_byte = 1'b1;
               state_in      = S_DEC;
            end
         end
         S_DEC: begin
            cmd.clr_scan = 1'b1;
            if (sts.is_delim || sts.eot) begin
               if (!sts.word_empty) state_in = S_LOAD;
               else if (sts.eot) state_in = S_RSP;
               else state_in = S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LOAD: begin
            if (sts.scan_end) begin
               if (sts.tab_full) state_in = S_RSP;
               else begin
                  cmd.write_new = 1'b1;
                  state_in      = S_COPY;
               end
            end else begin
               cmd.cmp_load = 1'b1;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            if (!sts.len_eq || !sts.byte_eq) begin
               cmd.next_entry = 1'b1;
               state_in       = S_LOAD;
            end else if (sts.bytes_end) begin
               state_in = S_HIT;
            end else begin
               cmd.next_byte = 1'b1;
               state_in      = S_LOAD;
            end
         end
         S_HIT: begin
            cmd.write_hit = 1'b1;
            state_in      = S_FIN;
         end
         // read back the updated count for the result
         S_FIN: begin
            cmd.cmp_load = 1'b1;
            state_in     = S_RSP;
         end
         S_COPY: begin
            cmd.copy_byte = 1'b1;
            if (sts.bytes_end) state_in = S_RSP;
         end
         S_RSP: begin
            cmd.load_rsp = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            rsp_valid_in  = 1'b1;
            cmd.word_clr  = 1'b1;
            cmd.tab_clr   = sts.eot;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/word_repeat_counter_top.sv
// ---------------------------------------------------------------------------
// word_repeat_counter_top
// Counts repeated words in a byte stream, one text byte per beat.
// ---------------------------------------------------------------------------
// Input beats carry one text byte in req_tdata and the end-of-text mark in
// req_tlast. A delimiter or end of text closes a pending word; the word is
// looked up in a table of up to MAX_WORDS entries and one result beat is
// produced on the rsp_ channel with entry index, count and flags.
// A byte that closes no word is latched and decoded only. A closing byte
// is latched and decoded, then the used entries are scanned byte by byte
// (a registered table read, then the compare; an entry that differs in
// length or in a byte is left at once). A hit writes the bumped count and
// reads it back; a new word is appended and its bytes copied in; a full
// table or end of text with no word goes straight to the result. The result
// is then valid, and the next beat is taken in the cycle after it leaves.
// Only one beat is worked on at a time. If the receiver stalls, the result
// holds in the output register and req_tready stays low.
// Reset clears the pending word, the entry count and the handshake state;
// table contents need no clearing since only used entries are read.
// End of text clears the table after its result.
// ---------------------------------------------------------------------------
module word_repeat_counter_top import wrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_index[4:0], occurrences[14:5], is_new_word[15], is_repeated[16],
   // word_truncated[17], table_full[18], text_done[19], zero fill
   output logic [23:0] rsp_tdata
);

   wrc_cmd_type cmd;
   wrc_sts_type sts;

   wrc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   wrc_datapath u_dp (
      .clock, .reset, .req_byte(req_tdata), .req_eot(req_tlast),
      .cmd, .sts, .rsp_data(rsp_tdata)
   );

endmodule

>>> hdl/wrc_checker.sv
// ---------------------------------------------------------------------------
// wrc_checker
// Port-level checks on the word repeat counter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CHK_IMPLY(a_no_take_busy, clock, reset, rsp_tvalid, !req_tready)
   `CHK_IMPLY(a_new_one, clock, reset, rsp_tvalid && rsp_tdata[15], rsp_tdata[14:5] == 10'd1)
   `CHK_IMPLY(a_full_zero, clock, reset, rsp_tvalid && rsp_tdata[18], rsp_tdata[16:0] == 17'd0)

endmodule

bind word_repeat_counter_top wrc_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
